// ===== design/marf_pkg.sv =====
// ---------------------------------------------------------------------------
// marf_pkg - shared types and constants for the adc rank filter
// sample width, register indexes, reset values and the cell link structs
// ---------------------------------------------------------------------------
`default_nettype none

package marf_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int CHAN_OUT_W    = 3;
  localparam int SETTLE_W      = 16;
  localparam int RANK_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam int DEF_CHANNELS      = 8;
  localparam int DEF_BURST_SAMPLES = 9;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd150;
  localparam logic [RANK_W-1:0]   RANK_RESET   = 4'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_RANK    = 2'd1;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;
    logic insert;
  } marf_ctl_t;

  // what one cell shows its right-hand neighbour
  typedef struct packed {
    logic                occ;
    logic                le;
    logic [SAMPLE_W-1:0] val;
  } marf_link_t;

endpackage

`default_nettype wire

// ===== design/marf_cell.sv =====
// ---------------------------------------------------------------------------
// marf_cell - one slot of the sorted insertion chain
// keeps its sample, takes the new one, takes the left neighbour's, or empties on clear
// ---------------------------------------------------------------------------
`default_nettype none

module marf_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  marf_pkg::marf_ctl_t             ctl,
  input  logic [marf_pkg::SAMPLE_W-1:0]   sample_in,
  input  marf_pkg::marf_link_t            left,
  output marf_pkg::marf_link_t            cell_out
);
  import marf_pkg::*;

  logic                occ_r;
  logic                occ_nxt;
  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;

  // an empty slot ranks above every sample
  assign cell_out.occ = occ_r;
  assign cell_out.le  = occ_r && (val_r <= sample_in);
  assign cell_out.val = val_r;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctl.insert && !cell_out.le) begin
      // new sample lands here if the left slot is not above it, else shift right
      val_nxt = left.le ? sample_in : left.val;
      occ_nxt = left.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ===== design/multichannel_adc_rank_filter_unit.sv =====
// an accepted request's result is registered and appears in the next cycle
// throughput: one request per cycle while the result side is not stalled
// each conversion sample is sorted into the cell chain in the cycle it is taken
// reset: synchronous, active low; phase idle, channel 0, counters 0, chain empty,
// settle_ticks 150, pick_rank 5
// ---------------------------------------------------------------------------
// multichannel_adc_rank_filter_unit - round-robin adc sequencer with rank pick
// collects a burst per channel, waits a settle time and emits the ranked sample
// ---------------------------------------------------------------------------
`default_nettype none

module multichannel_adc_rank_filter_unit #(
  parameter int CHANNELS      = marf_pkg::DEF_CHANNELS,
  parameter int BURST_SAMPLES = marf_pkg::DEF_BURST_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [marf_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_start_conversion,
  output logic [marf_pkg::CHAN_OUT_W-1:0]    out_channel_select,
  output logic                               out_value_valid,
  output logic [marf_pkg::CHAN_OUT_W-1:0]    out_value_channel,
  output logic [marf_pkg::SAMPLE_W-1:0]      out_filtered_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [marf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [marf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import marf_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(BURST_SAMPLES + 1);
  localparam int IDX_W = (BURST_SAMPLES > 1) ? $clog2(BURST_SAMPLES) : 1;

  localparam logic [CH_W-1:0]  CH_LAST    = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W:0]   BURST_FULL = (CNT_W + 1)'(BURST_SAMPLES);
  localparam logic [5:0]       RANK_MAX   = 6'(BURST_SAMPLES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_SETTLE
  } phase_t;

  // configuration registers
  logic [SETTLE_W-1:0] settle_ticks_r;
  logic [RANK_W-1:0]   pick_rank_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
      pick_rank_r    <= RANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SETTLE_TICKS) begin
        settle_ticks_r <= cfg_data;
      end else if (cfg_index == REG_PICK_RANK) begin
        pick_rank_r <= cfg_data[RANK_W-1:0];
      end
    end
  end

  // sequencer state and result register
  phase_t              phase_r, phase_nxt;
  logic [CH_W-1:0]     chan_r, chan_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SETTLE_W-1:0] tick_r, tick_nxt;

  logic                out_valid_r;
  logic                start_r, start_nxt;
  logic [CH_W-1:0]     sel_r;
  logic                vvalid_r, vvalid_nxt;
  logic [CH_W-1:0]     vchan_r, vchan_nxt;
  logic [SAMPLE_W-1:0] fval_r, fval_nxt;

  logic                accept;
  logic [CNT_W:0]      cnt_inc;
  marf_ctl_t           ctl;

  marf_link_t          links [BURST_SAMPLES];
  logic [BURST_SAMPLES-1:0] occ_vec;
  logic [5:0]          rank_ext;
  logic [IDX_W-1:0]    rank_idx;
  logic [SAMPLE_W-1:0] picked;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;

  // clamp rank to the last slot of the chain
  assign rank_ext = (6'(pick_rank_r) > RANK_MAX) ? RANK_MAX : 6'(pick_rank_r);
  assign rank_idx = rank_ext[IDX_W-1:0];
  assign picked   = links[rank_idx].val;

  always_comb begin
    phase_nxt  = phase_r;
    chan_nxt   = chan_r;
    cnt_nxt    = cnt_r;
    tick_nxt   = tick_r;
    start_nxt  = 1'b0;
    vvalid_nxt = 1'b0;
    vchan_nxt  = '0;
    fval_nxt   = '0;
    ctl        = '{clear: 1'b0, insert: 1'b0};
    unique case (phase_r)
      PH_IDLE: begin
        start_nxt = 1'b1;
        cnt_nxt   = '0;
        phase_nxt = PH_COLLECT;
        ctl.clear = accept;
      end
      PH_COLLECT: begin
        if (in_command == CMD_CONVERT) begin
          ctl.insert = accept;
          cnt_nxt    = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= BURST_FULL) begin
            tick_nxt  = '0;
            phase_nxt = PH_SETTLE;
          end else begin
            start_nxt = 1'b1;
          end
        end
      end
      PH_SETTLE: begin
        if (in_command == CMD_TICK && tick_r != '1) begin
          tick_nxt = tick_r + 1'b1;
        end
        if (tick_nxt >= settle_ticks_r) begin
          vvalid_nxt = 1'b1;
          vchan_nxt  = chan_r;
          fval_nxt   = picked;
          chan_nxt   = (chan_r == CH_LAST) ? '0 : chan_r + 1'b1;
          phase_nxt  = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      chan_r      <= '0;
      cnt_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        chan_r   <= chan_nxt;
        cnt_r    <= cnt_nxt;
        tick_r   <= tick_nxt;
        start_r  <= start_nxt;
        sel_r    <= chan_nxt;
        vvalid_r <= vvalid_nxt;
        vchan_r  <= vchan_nxt;
        fval_r   <= fval_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // insertion chain, sorted ascending from slot 0
  genvar gi;
  for (gi = 0; gi < BURST_SAMPLES; gi++) begin : g_cell
    marf_link_t left_link;
    if (gi == 0) begin : g_head
      assign left_link = '{occ: 1'b1, le: 1'b1, val: '0};
    end else begin : g_body
      assign left_link = links[gi-1];
    end
    marf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sample_in (in_sample),
      .left      (left_link),
      .cell_out  (links[gi])
    );
    assign occ_vec[gi] = links[gi].occ;
  end

  // widen or trim channel numbers to the three reported bits
  logic [CH_W+CHAN_OUT_W-1:0] sel_ext;
  logic [CH_W+CHAN_OUT_W-1:0] vchan_ext;
  assign sel_ext   = {{CHAN_OUT_W{1'b0}}, sel_r};
  assign vchan_ext = {{CHAN_OUT_W{1'b0}}, vchan_r};

  assign out_valid            = out_valid_r;
  assign out_start_conversion = start_r;
  assign out_channel_select   = sel_ext[CHAN_OUT_W-1:0];
  assign out_value_valid      = vvalid_r;
  assign out_value_channel    = vchan_ext[CHAN_OUT_W-1:0];
  assign out_filtered_value   = fval_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(cnt_r) <= BURST_FULL)
    else $error("burst count beyond burst length");

  a_full_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_SETTLE) |-> (occ_vec == '1))
    else $error("rank chain not full in settle phase");

  a_emit_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && vvalid_r) |-> !start_r)
    else $error("value emitted together with a conversion start");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire
